### hdl/assert_macros.svh
// Assertion macros for the modules that check their own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ITOA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define ITOA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### hdl/itoa_pkg.sv
// Types and constants shared by the integer-to-ASCII conversion modules.
package itoa_pkg;

  // Widths of the fixed input and output fields.
  localparam int VALUE_IN_W = 64;
  localparam int RADIX_W    = 6;
  localparam int CHAR_W     = 8;

  // Quotient bits resolved per divider cycle.
  localparam int STEP_BITS = 8;

  // Function codes.
  localparam logic FUNC_UNSIGNED = 1'b0;
  localparam logic FUNC_SIGNED   = 1'b1;

  // Base limits and the decimal base.
  localparam logic [RADIX_W-1:0] MIN_BASE = 6'd2;
  localparam logic [RADIX_W-1:0] MAX_BASE = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_BASE = 6'd10;

  // Character codes and letter offsets.
  localparam logic [CHAR_W-1:0] CHAR_ZERO     = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE     = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS    = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] UPPER_OFFSET  = 8'h37;  // 'A' - 10
  localparam logic [CHAR_W-1:0] LOWER_OFFSET  = 8'h57;  // 'a' - 10
  localparam logic [RADIX_W-1:0] LAST_DEC_DIGIT = 6'd9;

  // Classified command handed from the front to the back.
  typedef struct packed {
    logic [RADIX_W-1:0] base;
    logic               neg;
    logic               lower;
  } itoa_cmd_t;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_LOAD
  } back_state_e;

  // ASCII code of one digit value.
  function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                   input logic lower);
    logic [CHAR_W-1:0] ext;
    ext = {2'b00, d};
    if (d > LAST_DEC_DIGIT) begin
      digit_char = ext + (lower ? LOWER_OFFSET : UPPER_OFFSET);
    end else begin
      digit_char = ext + CHAR_ZERO;
    end
  endfunction

endpackage

### hdl/itoa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itoa_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port; data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### hdl/itoa_front.sv
// Front end: masks the value, takes the sign and magnitude and clamps the base, or forces base ten when signed.
module itoa_front #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                                func_i,
  input  logic [itoa_pkg::VALUE_IN_W-1:0]     value_i,
  input  logic [itoa_pkg::RADIX_W-1:0]        radix_i,
  input  logic                                lower_case_i,
  output logic [VALUE_WIDTH-1:0]              mag_o,
  output itoa_pkg::itoa_cmd_t                 cmd_o
);

  import itoa_pkg::*;

  logic [VALUE_WIDTH-1:0] value_masked;
  logic                   is_neg;

  assign value_masked = value_i[VALUE_WIDTH-1:0];
  assign is_neg       = (func_i == FUNC_SIGNED) && value_masked[VALUE_WIDTH-1];

  // Magnitude: two's complement negation for negative signed values.
  assign mag_o = is_neg ? (~value_masked + VALUE_WIDTH'(1)) : value_masked;

  // Base selection and clamping.
  always_comb begin
    cmd_o.neg   = is_neg;
    cmd_o.lower = lower_case_i;
    priority if (func_i == FUNC_SIGNED) begin
      cmd_o.base = DEC_BASE;
    end else if (radix_i < MIN_BASE) begin
      cmd_o.base = MIN_BASE;
    end else if (radix_i > MAX_BASE) begin
      cmd_o.base = MAX_BASE;
    end else begin
      cmd_o.base = radix_i;
    end
  end

endmodule

### hdl/itoa_queue.sv
// Short register queue between the front end and the back end.
module itoa_queue #(
  parameter int WIDTH = 72,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = slot_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

### hdl/itoa_back.sv
// Back end: iterative divider that stores digits, then emits an optional minus sign and the digits in reverse.
module itoa_back #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  logic [VALUE_WIDTH-1:0]        cmd_mag_i,
  input  itoa_pkg::itoa_cmd_t           cmd_i,
  output logic                          cmd_pop_o,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]   character_o,
  output logic                          last_o
);

  import itoa_pkg::*;

  localparam int NUM_CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_W      = NUM_CHUNKS * STEP_BITS;
  localparam int CHUNK_W    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int ADDR_W     = $clog2(VALUE_WIDTH);
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  back_state_e state_q, state_d;

  logic [PAD_W-1:0]   div_q, div_d;
  logic [RADIX_W-1:0] rem_q, rem_d;
  logic [CHUNK_W-1:0] chunk_q, chunk_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  itoa_cmd_t          cmd_q, cmd_d;
  logic               out_valid_q, out_valid_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic               last_q, last_d;

  logic [STEP_BITS-1:0] chunk_bits;
  logic [STEP_BITS-1:0] qbits;
  logic [RADIX_W-1:0]   step_rem;
  logic [RADIX_W:0]     trial;
  logic [PAD_W-1:0]     div_next;
  logic                 last_chunk;
  logic                 quot_zero;
  logic                 out_free;

  logic               ram_wr_en;
  logic               ram_rd_en;
  logic [RADIX_W-1:0] ram_rd_data;

  // One chunk of restoring division: one quotient bit per step.
  always_comb begin
    chunk_bits = div_q[PAD_W-1 -: STEP_BITS];
    step_rem   = rem_q;
    qbits      = '0;
    trial      = '0;
    for (int b = STEP_BITS - 1; b >= 0; b--) begin
      trial = {step_rem, chunk_bits[b]};
      if (trial >= {1'b0, cmd_q.base}) begin
        step_rem = RADIX_W'(trial - {1'b0, cmd_q.base});
        qbits[b] = 1'b1;
      end else begin
        step_rem = trial[RADIX_W-1:0];
      end
    end
  end

  assign div_next   = (div_q << STEP_BITS) | PAD_W'(qbits);
  assign last_chunk = (chunk_q == CHUNK_W'(NUM_CHUNKS - 1));
  assign quot_zero  = (div_next == '0);
  assign out_free   = !out_valid_q || !stall_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        if (last_chunk && quot_zero) begin
          state_d = cmd_q.neg ? ST_SIGN : ST_READ;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          state_d = (idx_q == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Datapath and handshake outputs.
  always_comb begin
    div_d       = div_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    cmd_d       = cmd_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && stall_i;
    cmd_pop_o   = 1'b0;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          div_d     = PAD_W'(cmd_mag_i);
          cmd_d     = cmd_i;
          rem_d     = '0;
          chunk_d   = '0;
          cnt_d     = '0;
        end
      end
      ST_DIV: begin
        div_d = div_next;
        if (last_chunk) begin
          ram_wr_en = 1'b1;
          cnt_d     = cnt_q + CNT_W'(1);
          idx_d     = cnt_q[ADDR_W-1:0];
          rem_d     = '0;
          chunk_d   = '0;
        end else begin
          rem_d   = step_rem;
          chunk_d = chunk_q + CHUNK_W'(1);
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = CHAR_MINUS;
          last_d      = 1'b0;
        end
      end
      ST_READ: begin
        ram_rd_en = 1'b1;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          char_d      = digit_char(ram_rd_data, cmd_q.lower);
          last_d      = (idx_q == '0);
          if (idx_q != '0) begin
            idx_d = idx_q - ADDR_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      chunk_q     <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      chunk_q     <= chunk_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    div_q  <= div_d;
    rem_q  <= rem_d;
    cmd_q  <= cmd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // Digit store, least significant digit at address zero.
  itoa_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (VALUE_WIDTH)
  ) u_digit_ram (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (cnt_q[ADDR_W-1:0]),
    .wr_data_i (step_rem),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (idx_q),
    .rd_data_o (ram_rd_data)
  );

  assign valid_o     = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;

endmodule

### hdl/integer_to_ascii_digits.sv
// Converts one integer per transaction into its ASCII digits, most significant
// first, one character per output transaction with last_o on the final one.
// The back end works on one number at a time. Its divider resolves eight
// quotient bits per cycle, passing over every chunk of the value for each digit;
// the digits then come out of the digit RAM through its registered read, each
// character being read in ST_READ and then sent from ST_LOAD, after a minus sign
// for negative values. Output stalls hold the emission. A two-entry queue lets
// the next number be taken while the current one is still converting.
`include "assert_macros.svh"

module integer_to_ascii_digits #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              stall_o,
  input  logic                              func_i,
  input  logic [itoa_pkg::VALUE_IN_W-1:0]   value_i,
  input  logic [itoa_pkg::RADIX_W-1:0]      radix_i,
  input  logic                              lower_case_i,
  output logic                              valid_o,
  input  logic                              stall_i,
  output logic [itoa_pkg::CHAR_W-1:0]       character_o,
  output logic                              last_o
);

  import itoa_pkg::*;

  localparam int CMD_W   = $bits(itoa_cmd_t);
  localparam int ENTRY_W = VALUE_WIDTH + CMD_W;

  logic [VALUE_WIDTH-1:0] front_mag;
  itoa_cmd_t              front_cmd;
  logic                   q_full;
  logic                   q_push;
  logic                   q_valid;
  logic                   q_pop;
  logic [ENTRY_W-1:0]     q_out;
  itoa_cmd_t              back_cmd;
  logic                   is_minus;
  logic                   in_char_set;

  // Classification of the incoming transaction.
  itoa_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .func_i       (func_i),
    .value_i      (value_i),
    .radix_i      (radix_i),
    .lower_case_i (lower_case_i),
    .mag_o        (front_mag),
    .cmd_o        (front_cmd)
  );

  // Command queue between front and back.
  assign stall_o = q_full;
  assign q_push  = valid_i && !q_full;

  itoa_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (2)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  ({front_mag, front_cmd}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign back_cmd = q_out[CMD_W-1:0];

  // Division and character emission.
  itoa_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_mag_i   (q_out[ENTRY_W-1:CMD_W]),
    .cmd_i       (back_cmd),
    .cmd_pop_o   (q_pop),
    .valid_o     (valid_o),
    .stall_i     (stall_i),
    .character_o (character_o),
    .last_o      (last_o)
  );

  // Character classes seen by the checks below.
  assign is_minus    = (character_o == CHAR_MINUS);
  assign in_char_set = (character_o >= CHAR_ZERO && character_o <= CHAR_NINE) ||
                       (character_o >= CHAR_UPPER_A && character_o <= CHAR_UPPER_Z) ||
                       (character_o >= CHAR_LOWER_A && character_o <= CHAR_LOWER_Z) ||
                       is_minus;

  // The back end only takes a command that the queue holds.
  `ITOA_ASSERT_NEVER(a_pop_empty, q_pop && !q_valid, "command taken from an empty queue")

  // A minus sign is never the final character of a number.
  `ITOA_ASSERT(a_minus_not_last, (valid_o && is_minus) |-> !last_o, "minus sign marked last")

  // Every character is a digit, a letter or a minus sign.
  `ITOA_ASSERT(a_char_set, valid_o |-> in_char_set, "character outside the digit set")

endmodule

### bench/integer_to_ascii_digits_tb.sv
// Self-checking testbench for the integer-to-ASCII digit converter.
module integer_to_ascii_digits_tb;
  import itoa_pkg::*;

  localparam int VALUE_WIDTH  = 64;
  localparam int TEXT_BYTES   = 24;
  localparam int RANDOM_ITEMS = 245;
  // Tail long enough for a 64-digit binary number in the back end.
  localparam int TAIL_CYCLES  = 700;
  localparam int IDLE_LIMIT   = 20000;
  localparam int NUM_DIRECTED = 25;

  localparam logic [VALUE_IN_W-1:0] ALL_ONES = {VALUE_IN_W{1'b1}};
  localparam logic [VALUE_IN_W-1:0] MIN_NEG  = {1'b1, {(VALUE_IN_W-1){1'b0}}};
  localparam logic [VALUE_IN_W-1:0] MAX_POS  = {1'b0, {(VALUE_IN_W-1){1'b1}}};
  localparam logic [VALUE_IN_W-1:0] WIDTH_MASK =
    (VALUE_WIDTH >= VALUE_IN_W) ? ALL_ONES : ((64'd1 << VALUE_WIDTH) - 64'd1);

  // One expected output character.
  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_result_t;

  // One directed row; a zero text means the predictor supplies the digits.
  typedef struct packed {
    logic                    func;
    logic [VALUE_IN_W-1:0]   value;
    logic [RADIX_W-1:0]      radix;
    logic                    lower;
    logic [8*TEXT_BYTES-1:0] text;
  } directed_row_t;

  // Receiver stall patterns, cycled through by a free-running counter.
  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_SPARSE,
    STALL_HEAVY,
    STALL_HALF
  } stall_mode_e;

  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{FUNC_UNSIGNED, 64'd0, 6'd10, 1'b0, "0"},
    '{FUNC_UNSIGNED, 64'd1, 6'd2, 1'b0, "1"},
    '{FUNC_UNSIGNED, ALL_ONES, 6'd2, 1'b0, '0},
    '{FUNC_UNSIGNED, ALL_ONES, 6'd16, 1'b0, "FFFFFFFFFFFFFFFF"},
    '{FUNC_UNSIGNED, ALL_ONES, 6'd16, 1'b1, "ffffffffffffffff"},
    '{FUNC_UNSIGNED, 64'd35, 6'd36, 1'b1, "z"},
    '{FUNC_UNSIGNED, 64'd35, 6'd36, 1'b0, "Z"},
    '{FUNC_UNSIGNED, 64'd255, 6'd0, 1'b0, "11111111"},
    '{FUNC_UNSIGNED, 64'd255, 6'd1, 1'b1, "11111111"},
    '{FUNC_UNSIGNED, 64'd35, 6'd63, 1'b0, "Z"},
    '{FUNC_UNSIGNED, 64'd35, 6'd37, 1'b1, "z"},
    '{FUNC_UNSIGNED, 64'd9, 6'd10, 1'b0, "9"},
    '{FUNC_UNSIGNED, 64'd10, 6'd10, 1'b0, "10"},
    '{FUNC_UNSIGNED, ALL_ONES, 6'd10, 1'b0, "18446744073709551615"},
    '{FUNC_UNSIGNED, MIN_NEG, 6'd10, 1'b0, "9223372036854775808"},
    '{FUNC_UNSIGNED, ALL_ONES, 6'd36, 1'b1, '0},
    '{FUNC_UNSIGNED, ALL_ONES, 6'd3, 1'b0, '0},
    '{FUNC_UNSIGNED, 64'hDEAD_BEEF_0123_4567, 6'd7, 1'b1, '0},
    '{FUNC_SIGNED, 64'd0, 6'd10, 1'b0, "0"},
    '{FUNC_SIGNED, ALL_ONES, 6'd10, 1'b0, "-1"},
    '{FUNC_SIGNED, MIN_NEG, 6'd10, 1'b0, "-9223372036854775808"},
    '{FUNC_SIGNED, MAX_POS, 6'd10, 1'b1, "9223372036854775807"},
    '{FUNC_SIGNED, 64'd12345, 6'd2, 1'b0, "12345"},
    '{FUNC_SIGNED, 64'hFFFF_FFFF_FFFF_FFF6, 6'd63, 1'b1, "-10"},
    '{FUNC_SIGNED, 64'h0123_4567_89AB_CDEF, 6'd0, 1'b0, '0}
  };

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  valid_i      = 1'b0;
  logic                  stall_o;
  logic                  func_i       = FUNC_UNSIGNED;
  logic [VALUE_IN_W-1:0] value_i      = '0;
  logic [RADIX_W-1:0]    radix_i      = '0;
  logic                  lower_case_i = 1'b0;
  logic                  valid_o;
  logic                  stall_i      = 1'b0;
  logic [CHAR_W-1:0]     character_o;
  logic                  last_o;

  char_result_t pending_chars[$];
  int           fail_count     = 0;
  int           numbers_sent   = 0;
  int           signed_sent    = 0;
  int           negative_sent  = 0;
  int           chars_checked  = 0;
  int           idle_cycles    = 0;
  logic [7:0]   stall_tick     = '0;

  integer_to_ascii_digits #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) uut (
    .clk_i,
    .rst_ni,
    .valid_i,
    .stall_o,
    .func_i,
    .value_i,
    .radix_i,
    .lower_case_i,
    .valid_o,
    .stall_i,
    .character_o,
    .last_o
  );

  always #2 clk_i = ~clk_i;

  // Expected characters of one number, most significant first.
  function automatic void predict_digits(input logic f, input logic [VALUE_IN_W-1:0] v,
                                         input logic [RADIX_W-1:0] r, input logic lc);
    logic [VALUE_IN_W-1:0] rest;
    logic [VALUE_IN_W-1:0] base;
    logic [RADIX_W-1:0]    digits [64];
    logic [CHAR_W-1:0]     ch;
    logic                  neg;
    int                    count;
    int                    i;
    rest = v & WIDTH_MASK;
    neg  = 1'b0;
    if (f == FUNC_SIGNED) begin
      base = VALUE_IN_W'(DEC_BASE);
      neg  = rest[VALUE_WIDTH-1];
      if (neg) begin
        rest = (-rest) & WIDTH_MASK;
      end
    end else if (r < MIN_BASE) begin
      base = VALUE_IN_W'(MIN_BASE);
    end else if (r > MAX_BASE) begin
      base = VALUE_IN_W'(MAX_BASE);
    end else begin
      base = VALUE_IN_W'(r);
    end
    // Remainders come out least significant first.
    count = 0;
    do begin
      digits[count] = RADIX_W'(rest % base);
      rest = rest / base;
      count++;
    end while (rest != 0 && count < 64);
    if (neg) begin
      pending_chars.push_back('{CHAR_MINUS, 1'b0});
    end
    for (i = count - 1; i >= 0; i--) begin
      if (digits[i] > LAST_DEC_DIGIT) begin
        ch = {2'b00, digits[i]} + (lc ? LOWER_OFFSET : UPPER_OFFSET);
      end else begin
        ch = {2'b00, digits[i]} + CHAR_ZERO;
      end
      pending_chars.push_back('{ch, i == 0});
    end
  endfunction

  // Presents one number and records its characters once the transaction is taken.
  task automatic drive_item(input logic f, input logic [VALUE_IN_W-1:0] v,
                            input logic [RADIX_W-1:0] r, input logic lc,
                            input logic [8*TEXT_BYTES-1:0] text);
    int n;
    int k;
    valid_i      <= 1'b1;
    func_i       <= f;
    value_i      <= v;
    radix_i      <= r;
    lower_case_i <= lc;
    @(posedge clk_i);
    while (stall_o) begin
      @(posedge clk_i);
    end
    numbers_sent++;
    if (f == FUNC_SIGNED) begin
      signed_sent++;
      if (v[VALUE_WIDTH-1]) begin
        negative_sent++;
      end
    end
    if (text == '0) begin
      predict_digits(f, v, r, lc);
    end else begin
      // Typed-in text is right aligned; its length is the run of nonzero bytes.
      n = 0;
      while (n < TEXT_BYTES && text[8*n +: 8] != 8'h00) begin
        n++;
      end
      for (k = n - 1; k >= 0; k--) begin
        pending_chars.push_back('{text[8*k +: 8], k == 0});
      end
    end
  endtask

  // Holds the sender off until every expected character has arrived.
  task automatic wait_for_drain();
    valid_i <= 1'b0;
    do begin
      @(posedge clk_i);
    end while (pending_chars.size() != 0);
  endtask

  // Receiver stall pattern, switching with the top bits of a free-running counter.
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 8'd1;
    case (stall_mode_e'(stall_tick[7:6]))
      STALL_NONE: begin
        stall_i <= 1'b0;
      end
      STALL_SPARSE: begin
        stall_i <= ($urandom_range(0, 3) == 0);
      end
      STALL_HEAVY: begin
        stall_i <= (stall_tick[1:0] != 2'd0);
      end
      default: begin
        stall_i <= 1'($urandom_range(0, 1));
      end
    endcase
  end

  // Compare each output transaction with the oldest expected character.
  always @(posedge clk_i) begin : check_output
    char_result_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character %h (last %b)", character_o, last_o);
        fail_count++;
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (character_o !== want.ch) begin
          $error("character: expected %h, got %h", want.ch, character_o);
          fail_count++;
        end
        if (last_o !== want.last) begin
          $error("last: expected %b, got %b", want.last, last_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no transaction on either side.
  always @(posedge clk_i) begin
    if (!rst_ni || (valid_i && !stall_o) || (valid_o && !stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $error("no transaction for %0d cycles", IDLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int                    idx;
    int                    sent;
    int                    burst;
    int                    gap;
    logic                  f;
    logic [VALUE_IN_W-1:0] v;
    logic [RADIX_W-1:0]    r;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: extremes, letter cases, clamped bases and signed corners.
    for (idx = 0; idx < NUM_DIRECTED; idx++) begin
      drive_item(DIRECTED_ROWS[idx].func, DIRECTED_ROWS[idx].value,
                 DIRECTED_ROWS[idx].radix, DIRECTED_ROWS[idx].lower,
                 DIRECTED_ROWS[idx].text);
    end
    wait_for_drain();

    // Random numbers in bursts with gaps of varying length.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 8);
      while (burst > 0 && sent < RANDOM_ITEMS) begin
        f = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 7))
          0: v = '0;
          1: v = ALL_ONES;
          2: v = MIN_NEG;
          3: v = VALUE_IN_W'($urandom_range(0, 100));
          4, 5: v = {$urandom, $urandom} >> $urandom_range(0, 63);
          default: v = {$urandom, $urandom};
        endcase
        if ($urandom_range(0, 7) == 0) begin
          r = RADIX_W'($urandom_range(0, 63));
        end else begin
          r = RADIX_W'($urandom_range(2, 36));
        end
        drive_item(f, v, r, 1'($urandom_range(0, 1)), '0);
        sent++;
        burst--;
        if (sent == RANDOM_ITEMS / 2) begin
          wait_for_drain();
        end
      end
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(20, 400);
        default: gap = $urandom_range(1, 12);
      endcase
      if (gap > 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("Converted %0d numbers (%0d signed decimal, %0d negative) into %0d characters,",
             numbers_sent, signed_sent, negative_sent, chars_checked);
    $display("covering bases 2 to 36, clamped bases and both letter cases under random stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/itoa_pkg.sv
hdl/itoa_ram.sv
hdl/itoa_front.sv
hdl/itoa_queue.sv
hdl/itoa_back.sv
hdl/integer_to_ascii_digits.sv
bench/integer_to_ascii_digits_tb.sv
